// ===== design/fpm_pkg.sv =====
package fpm_pkg;

    localparam int Bias     = 127;
    localparam int FracBits = 23;
    localparam int SigBits  = FracBits + 1;
    localparam int ProdBits = 2 * SigBits;

    // front to back: classified item
    typedef struct packed {
        logic                  sign;
        logic                  zero;
        logic                  range_err;
        logic signed [9:0]     sum;
        logic [SigBits-1:0]    ma;
        logic [SigBits-1:0]    mb;
    } fpm_item_t;

    localparam int ItemBits = $bits(fpm_item_t);

endpackage

// ===== design/fp32_multiplier_top.sv =====
// Single-precision multiplier.
// Input channel: in_valid / in_stall with operand_a, operand_b (IEEE-754 bit
// patterns). Output channel: out_valid / out_stall with product and
// range_error. An item moves when valid is high and stall is low.
// One item is accepted every cycle while in_stall is low; throughput is then one per cycle.
// From acceptance to out_valid an item passes a classify register in the
// front, then a two-entry registered queue, then the multiply register and
// the round/pack register in the back: four register stages in series.
// Zero operands give +0; else an exponent sum outside -127..127 gives +0 with
// range_error; overflow saturates to signed infinity, underflow flushes to
// signed zero. Infinity, NaN and subnormal inputs are treated as numbers.
// Reset clears all valid flags; no result is pending after reset.
// When the receiver stalls, the result holds; the back fills, then the
// queue, then the front register, then in_stall rises. Nothing is lost or repeated.
module fp32_multiplier_top
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [31:0] operand_a,
    input  logic [31:0] operand_b,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [31:0] product,
    output logic        range_error
);

    fpm_pkg::fpm_item_t f_item;
    fpm_pkg::fpm_item_t b_item;
    logic               f_valid;
    logic               f_stall;
    logic               b_valid;
    logic               b_stall;

    fpm_front u_front
    (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_stall(in_stall),
        .operand_a(operand_a), .operand_b(operand_b),
        .q_valid(f_valid), .q_stall(f_stall), .q_item(f_item)
    );

    fpm_queue u_queue
    (
        .clk(clk), .rst_n(rst_n),
        .wr_valid(f_valid), .wr_stall(f_stall), .wr_item(f_item),
        .rd_valid(b_valid), .rd_stall(b_stall), .rd_item(b_item)
    );

    fpm_back u_back
    (
        .clk(clk), .rst_n(rst_n),
        .q_valid(b_valid), .q_stall(b_stall), .q_item(b_item),
        .out_valid(out_valid), .out_stall(out_stall),
        .product(product), .range_error(range_error)
    );

endmodule

// ===== design/fpm_front.sv =====
module fpm_front
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_stall,
    input  logic [31:0]        operand_a,
    input  logic [31:0]        operand_b,
    output logic               q_valid,
    input  logic               q_stall,
    output fpm_pkg::fpm_item_t q_item
);

    fpm_pkg::fpm_item_t item_next;
    fpm_pkg::fpm_item_t item_reg;
    logic               valid_reg;
    logic [7:0]         ea;
    logic [7:0]         eb;
    logic signed [9:0]  s;

    assign ea = operand_a[30:23];
    assign eb = operand_b[30:23];
    assign s  = $signed({2'b00, ea}) + $signed({2'b00, eb}) - 10'sd254;

    always_comb
    begin
        item_next.sign      = operand_a[31] ^ operand_b[31];
        item_next.zero      = (ea == 8'd0 && operand_a[22:0] == 23'd0) ||
                              (eb == 8'd0 && operand_b[22:0] == 23'd0);
        item_next.range_err = (s < -10'sd127) || (s > 10'sd127);
        item_next.sum       = s;
        item_next.ma        = {1'b1, operand_a[22:0]};
        item_next.mb        = {1'b1, operand_b[22:0]};
    end

    assign in_stall = valid_reg && q_stall;
    assign q_valid  = valid_reg;
    assign q_item   = item_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (!in_stall)
        begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (!in_stall && in_valid)
        begin
            item_reg <= item_next;
        end
    end

endmodule

// ===== design/fpm_queue.sv =====
module fpm_queue
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               wr_valid,
    output logic               wr_stall,
    input  fpm_pkg::fpm_item_t wr_item,
    output logic               rd_valid,
    input  logic               rd_stall,
    output fpm_pkg::fpm_item_t rd_item
);

    // two-entry queue: main plus skid
    fpm_pkg::fpm_item_t ent_reg [2];
    logic [1:0]         cnt_reg;
    logic               head_reg;
    logic               push;
    logic               pop;

    assign wr_stall = (cnt_reg == 2'd2);
    assign rd_valid = (cnt_reg != 2'd0);
    assign rd_item  = ent_reg[head_reg];
    assign push     = wr_valid && !wr_stall;
    assign pop      = rd_valid && !rd_stall;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg  <= 2'd0;
            head_reg <= 1'b0;
        end
        else
        begin
            cnt_reg <= cnt_reg + {1'b0, push} - {1'b0, pop};
            if (pop)
            begin
                head_reg <= ~head_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            ent_reg[head_reg ^ cnt_reg[0]] <= wr_item;
        end
    end

`ifndef SYNTHESIS
    a_cnt_max: assert property (@(posedge clk) disable iff (!rst_n) cnt_reg <= 2'd2)
        else $error("queue count overflow");
    a_full_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (cnt_reg == 2'd2 && rd_stall) |=> cnt_reg == 2'd2)
        else $error("full queue lost an item");
    a_empty_novalid: assert property (@(posedge clk) disable iff (!rst_n)
        (cnt_reg == 2'd0) |-> !rd_valid)
        else $error("valid from empty queue");
`endif

endmodule

// ===== design/fpm_back.sv =====
module fpm_back
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               q_valid,
    output logic               q_stall,
    input  fpm_pkg::fpm_item_t q_item,
    output logic               out_valid,
    input  logic               out_stall,
    output logic [31:0]        product,
    output logic               range_error
);

    // stage 1: multiply; stage 2: round and pack
    logic                              v1_reg;
    logic                              v2_reg;
    logic [fpm_pkg::ProdBits-1:0]      p_reg;
    logic                              sign_reg;
    logic                              zero_reg;
    logic                              rerr_reg;
    logic signed [9:0]                 sum_reg;
    logic [31:0]                       prod_reg;
    logic                              err_reg;
    logic                              adv2;
    logic                              adv1;
    logic [31:0]                       prod_next;
    logic [24:0]                       m;
    logic                              g;
    logic                              st;
    logic [24:0]                       mr;
    logic signed [9:0]                 e;

    assign adv2     = !(v2_reg && out_stall);
    assign adv1     = adv2 || !v1_reg;
    assign q_stall  = !adv1;
    assign out_valid   = v2_reg;
    assign product     = prod_reg;
    assign range_error = err_reg;

    always_comb
    begin
        if (p_reg[47])
        begin
            m  = {1'b0, p_reg[47:24]};
            g  = p_reg[23];
            st = |p_reg[22:0];
            e  = sum_reg + 10'sd1;
        end
        else
        begin
            m  = {1'b0, p_reg[46:23]};
            g  = p_reg[22];
            st = |p_reg[21:0];
            e  = sum_reg;
        end
        mr = m + {24'd0, g && (st || m[0])};
        if (mr[24])
        begin
            mr = mr >> 1;
            e  = e + 10'sd1;
        end
        if (zero_reg || rerr_reg)
        begin
            prod_next = 32'd0;
        end
        else if (e >= 10'sd128)
        begin
            prod_next = {sign_reg, 8'hFF, 23'd0};
        end
        else if (e < -10'sd126)
        begin
            prod_next = {sign_reg, 31'd0};
        end
        else
        begin
            prod_next = {sign_reg, e[7:0] + 8'd127, mr[22:0]};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
        end
        else
        begin
            if (adv1)
            begin
                v1_reg <= q_valid;
            end
            if (adv2)
            begin
                v2_reg <= v1_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv1 && q_valid)
        begin
            p_reg    <= q_item.ma * q_item.mb;
            sign_reg <= q_item.sign;
            zero_reg <= q_item.zero;
            rerr_reg <= q_item.range_err;
            sum_reg  <= q_item.sum;
        end
        if (adv2 && v1_reg)
        begin
            prod_reg <= prod_next;
            err_reg  <= rerr_reg && !zero_reg;
        end
    end

`ifndef SYNTHESIS
    a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && range_error) |-> product == 32'd0)
        else $error("range error with nonzero product");
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && out_stall) |=> out_valid && $stable(product))
        else $error("stalled result changed");
    a_stall: assert property (@(posedge clk) disable iff (!rst_n)
        q_stall |-> (v1_reg && v2_reg && out_stall))
        else $error("back stalled without cause");
`endif

endmodule
